FILE: rtl/core/qjmt_pkg.sv
package qjmt_pkg;

   // Field widths of the two channels.
   localparam int IN_W   = 32;
   localparam int DUR_W  = 24;
   localparam int COEF_W = 64;

   // Signed width of the per-coefficient weights k0, k1 and k2.
   localparam int KW     = 40;
   // Magnitude and signed width of a numerator k0*2^2F + k1*D*2^F + k2*D^2.
   localparam int NW     = 88;
   localparam int NSW    = NW + 1;
   // Quotient bits kept by the divider: 64 result bits plus two overflow bits.
   localparam int Q_W    = COEF_W + 2;

   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

   typedef struct packed {
      logic signed [IN_W-1:0] start_position;
      logic signed [IN_W-1:0] start_velocity;
      logic signed [IN_W-1:0] start_accel;
      logic signed [IN_W-1:0] end_position;
      logic signed [IN_W-1:0] end_velocity;
      logic signed [IN_W-1:0] end_accel;
      logic [DUR_W-1:0]       duration;
   } qjmt_req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef0;
      logic signed [COEF_W-1:0] coef1;
      logic signed [COEF_W-1:0] coef2;
      logic signed [COEF_W-1:0] coef3;
      logic signed [COEF_W-1:0] coef4;
      logic signed [COEF_W-1:0] coef5;
      logic                     singular;
      logic                     saturated;
   } qjmt_rsp_type;

endpackage

FILE: rtl/core/qjmt_mul.sv
// Two-stage unsigned multiply of a wide operand by the 24-bit duration.
// The wide operand is cut into 24-bit chunks; the partial products of even
// and odd chunks do not overlap, so one wide add joins them.
module qjmt_mul import qjmt_pkg::*; #(
   parameter int A_W = 48
) (
   input  logic                   clock,
   input  logic [A_W-1:0]         a,
   input  logic [DUR_W-1:0]       d,
   output logic [A_W+DUR_W-1:0]   p
);

   localparam int NC  = (A_W + DUR_W - 1) / DUR_W;
   localparam int PAD = NC * DUR_W;
   localparam int SW  = PAD + DUR_W;

   logic [PAD-1:0]         a_pad;
   logic [2*DUR_W-1:0]     prod_ff [NC];
   logic [SW-1:0]          even_w;
   logic [SW-1:0]          odd_w;
   logic [SW-1:0]          sum_w;
   logic [A_W+DUR_W-1:0]   p_ff;

   assign a_pad = PAD'(a);

   // Chunk products.
   always_ff @(posedge clock) begin
      for (int i = 0; i < NC; i++) begin
         prod_ff[i] <= (2*DUR_W)'(a_pad[i*DUR_W +: DUR_W]) * (2*DUR_W)'(d);
      end
   end

   // Lay the products out in two non-overlapping rows and add them.
   always_comb begin
      even_w = '0;
      odd_w  = '0;
      for (int i = 0; i < NC; i++) begin
         if ((i & 1) == 0) begin
            even_w[i*DUR_W +: 2*DUR_W] = prod_ff[i];
         end else begin
            odd_w[i*DUR_W +: 2*DUR_W] = prod_ff[i];
         end
      end
      sum_w = even_w + odd_w;
   end

   always_ff @(posedge clock) begin
      p_ff <= sum_w[A_W+DUR_W-1:0];
   end

   assign p = p_ff;

endmodule

FILE: rtl/core/qjmt_div.sv
// Pipelined restoring divider with rounding and clamping.
// Computes round(mag * 2^SHIFT / den), ties away from zero, applies the sign
// and clamps to the signed 64-bit range. One quotient bit per stage.
module qjmt_div import qjmt_pkg::*; #(
   parameter int SHIFT = 31,
   parameter int DEN_W = 72
) (
   input  logic              clock,
   input  logic [NW-1:0]     mag,
   input  logic              neg,
   input  logic              zero,
   input  logic [DEN_W-1:0]  den,
   output logic [COEF_W-1:0] coef,
   output logic              sat
);

   localparam int XW  = NW + SHIFT + 2;
   localparam int YW  = DEN_W + 1 + Q_W;
   localparam int RW  = ((XW > YW) ? XW : YW) + 1;
   localparam int NST = Q_W;

   logic [RW-1:0]     rem_ff  [0:NST];
   logic [DEN_W:0]    y_ff    [0:NST];
   logic [Q_W-1:0]    q_ff    [0:NST];
   logic              neg_ff  [0:NST];
   logic              zero_ff [0:NST];
   logic [RW-1:0]     trial_w [1:NST];
   logic              take_w  [1:NST];
   logic [COEF_W-1:0] coef_ff;
   logic              sat_ff;
   logic [COEF_W-1:0] q_lo;
   logic              over;

   // Trial subtraction of the shifted divisor in each stage.
   always_comb begin
      for (int j = 1; j <= NST; j++) begin
         trial_w[j] = RW'(y_ff[j-1]) << (NST - j);
         take_w[j]  = rem_ff[j-1] >= trial_w[j];
      end
   end

   // Dividend 2*mag*2^SHIFT + den over divisor 2*den rounds half away from zero.
   always_ff @(posedge clock) begin
      rem_ff[0]  <= (RW'(mag) << (SHIFT + 1)) + RW'(den);
      y_ff[0]    <= {den, 1'b0};
      q_ff[0]    <= '0;
      neg_ff[0]  <= neg;
      zero_ff[0] <= zero;
      for (int j = 1; j <= NST; j++) begin
         rem_ff[j]  <= take_w[j] ? (rem_ff[j-1] - trial_w[j]) : rem_ff[j-1];
         q_ff[j]    <= q_ff[j-1] | (Q_W'(take_w[j]) << (NST - j));
         y_ff[j]    <= y_ff[j-1];
         neg_ff[j]  <= neg_ff[j-1];
         zero_ff[j] <= zero_ff[j-1];
      end
   end

   assign q_lo = q_ff[NST][COEF_W-1:0];
   assign over = q_ff[NST][Q_W-1] | q_ff[NST][Q_W-2];

   // Sign, clamp, and the zero-duration override.
   always_ff @(posedge clock) begin
      if (zero_ff[NST]) begin
         coef_ff <= '0;
         sat_ff  <= 1'b0;
      end else if (!neg_ff[NST]) begin
         if (over || q_lo[COEF_W-1]) begin
            coef_ff <= COEF_MAX;
            sat_ff  <= 1'b1;
         end else begin
            coef_ff <= q_lo;
            sat_ff  <= 1'b0;
         end
      end else begin
         if (over || (q_lo > COEF_MIN)) begin
            coef_ff <= COEF_MIN;
            sat_ff  <= 1'b1;
         end else begin
            coef_ff <= -q_lo;
            sat_ff  <= 1'b0;
         end
      end
   end

   assign coef = coef_ff;
   assign sat  = sat_ff;

endmodule

FILE: rtl/core/quintic_jerk_min_trajectory.sv
// Minimum-jerk quintic coefficient engine. A request is taken on every clock
// edge where start is high and busy is low; busy is high only during reset and
// in the cycle after it, so a new request may follow in every cycle. Each result
// appears on rsp_data with rsp_valid high for exactly one cycle, in request
// order; the receiver cannot stall, so results must be captured when rsp_valid
// is high. The latency is set by the chain of multiplies by the duration that
// builds T^5 and by the three bit-per-stage dividers, which run in parallel,
// one per higher coefficient, and need 66 stages each. A zero duration sets
// singular and gives zero higher coefficients.
module quintic_jerk_min_trajectory import qjmt_pkg::*; #(
   parameter int INPUT_FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  qjmt_req_type  req_data,
   output logic          rsp_valid,
   output qjmt_rsp_type  rsp_data
);

   localparam int LAST = 77;
   localparam int MW1  = KW - 1 + DUR_W;
   localparam int MW2  = MW1 + DUR_W;

   typedef struct packed {
      logic [COEF_W-1:0] coef0;
      logic [COEF_W-1:0] coef1;
      logic [COEF_W-1:0] coef2;
      logic              singular;
   } side_type;

   logic                  busy_ff;
   logic [LAST:0]         vld_ff;
   logic                  rsp_valid_ff;
   qjmt_rsp_type          rsp_ff;
   qjmt_req_type          req_ff;
   side_type              side_in;
   side_type              side_ff [1:LAST];
   logic [DUR_W-1:0]      d_ff    [1:7];

   logic signed [KW-1:0]  k0_in   [3];
   logic signed [KW-1:0]  k1_in   [3];
   logic signed [KW-1:0]  k2_in   [3];
   logic signed [KW-1:0]  k0_ff   [3][1:5];
   logic [1:0]            sg_ff   [3][1:5];
   logic [KW-2:0]         k1m_ff  [3];
   logic [KW-2:0]         k2m_ff  [3];
   logic [MW1-1:0]        k1d_w   [3];
   logic [MW1-1:0]        k1d_ff  [3][4:5];
   logic [MW1-1:0]        k2d_w   [3];
   logic [MW2-1:0]        k2dd_w  [3];
   logic [NSW-1:0]        n_in    [3];
   logic [NSW-1:0]        n_ff    [3];
   logic [NW-1:0]         mag_ff  [3][7:9];
   logic                  neg_ff  [3][7:9];

   logic [2*DUR_W-1:0]    dd_w;
   logic [3*DUR_W-1:0]    d3_w;
   logic [4*DUR_W-1:0]    d4_w;
   logic [5*DUR_W-1:0]    d5_w;
   logic [3*DUR_W-1:0]    d3_ff   [6:9];
   logic [4*DUR_W-1:0]    d4_ff   [8:9];

   logic [COEF_W-1:0]     coef_w  [3];
   logic                  sat_w   [3];
   logic                  accept;

   assign accept = start && !busy_ff;

   // Control: busy after reset, valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         vld_ff       <= {vld_ff[LAST-1:0], accept};
         rsp_valid_ff <= vld_ff[LAST];
      end
   end

   // Weights of the three closed-form numerators and the exact coefficients.
   always_comb begin
      logic signed [KW-1:0] p0, v0, a0, p1, v1, a1, dp, vs;
      p0 = {{(KW-IN_W){req_ff.start_position[IN_W-1]}}, req_ff.start_position};
      v0 = {{(KW-IN_W){req_ff.start_velocity[IN_W-1]}}, req_ff.start_velocity};
      a0 = {{(KW-IN_W){req_ff.start_accel[IN_W-1]}}, req_ff.start_accel};
      p1 = {{(KW-IN_W){req_ff.end_position[IN_W-1]}}, req_ff.end_position};
      v1 = {{(KW-IN_W){req_ff.end_velocity[IN_W-1]}}, req_ff.end_velocity};
      a1 = {{(KW-IN_W){req_ff.end_accel[IN_W-1]}}, req_ff.end_accel};
      dp = p1 - p0;
      vs = v0 + v1;
      k0_in[0] = (dp <<< 4) + (dp <<< 2);
      k1_in[0] = -((v0 <<< 3) + (v0 <<< 2) + (v1 <<< 3));
      k2_in[0] = a1 - (a0 <<< 1) - a0;
      k0_in[1] = (dp <<< 1) - (dp <<< 5);
      k1_in[1] = (v0 <<< 4) + (v1 <<< 4) - (v1 <<< 1);
      k2_in[1] = (a0 <<< 1) + a0 - (a1 <<< 1);
      k0_in[2] = (dp <<< 3) + (dp <<< 2);
      k1_in[2] = -((vs <<< 2) + (vs <<< 1));
      k2_in[2] = a1 - a0;
      side_in.coef0 = {{(COEF_W-IN_W){req_ff.start_position[IN_W-1]}},
                       req_ff.start_position} << (32 - INPUT_FRAC_BITS);
      side_in.coef1 = {{(COEF_W-IN_W){req_ff.start_velocity[IN_W-1]}},
                       req_ff.start_velocity} << (32 - INPUT_FRAC_BITS);
      side_in.coef2 = {{(COEF_W-IN_W){req_ff.start_accel[IN_W-1]}},
                       req_ff.start_accel} << (31 - INPUT_FRAC_BITS);
      side_in.singular = (req_ff.duration == '0);
   end

   // Numerator assembly and its magnitude.
   always_comb begin
      logic [NSW-1:0] t0, t1, t2;
      for (int c = 0; c < 3; c++) begin
         t0 = {{(NSW-KW){k0_ff[c][5][KW-1]}}, k0_ff[c][5]} << (2 * INPUT_FRAC_BITS);
         t1 = NSW'(k1d_ff[c][5]) << INPUT_FRAC_BITS;
         t2 = NSW'(k2dd_w[c]);
         if (sg_ff[c][5][1]) begin
            t1 = -t1;
         end
         if (sg_ff[c][5][0]) begin
            t2 = -t2;
         end
         n_in[c] = t0 + t1 + t2;
      end
   end

   // Data pipeline registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      side_ff[1] <= side_in;
      for (int s = 2; s <= LAST; s++) begin
         side_ff[s] <= side_ff[s-1];
      end
      d_ff[1] <= req_ff.duration;
      for (int s = 2; s <= 7; s++) begin
         d_ff[s] <= d_ff[s-1];
      end
      for (int c = 0; c < 3; c++) begin
         k0_ff[c][1]  <= k0_in[c];
         sg_ff[c][1]  <= {k1_in[c][KW-1], k2_in[c][KW-1]};
         k1m_ff[c]    <= k1_in[c][KW-1] ? (KW-1)'(-k1_in[c]) : (KW-1)'(k1_in[c]);
         k2m_ff[c]    <= k2_in[c][KW-1] ? (KW-1)'(-k2_in[c]) : (KW-1)'(k2_in[c]);
         for (int s = 2; s <= 5; s++) begin
            k0_ff[c][s] <= k0_ff[c][s-1];
            sg_ff[c][s] <= sg_ff[c][s-1];
         end
         k1d_ff[c][4] <= k1d_w[c];
         k1d_ff[c][5] <= k1d_ff[c][4];
         n_ff[c]      <= n_in[c];
         neg_ff[c][7] <= n_ff[c][NSW-1];
         mag_ff[c][7] <= n_ff[c][NSW-1] ? NW'(-n_ff[c]) : NW'(n_ff[c]);
         for (int s = 8; s <= 9; s++) begin
            mag_ff[c][s] <= mag_ff[c][s-1];
            neg_ff[c][s] <= neg_ff[c][s-1];
         end
      end
      d3_ff[6] <= d3_w;
      for (int s = 7; s <= 9; s++) begin
         d3_ff[s] <= d3_ff[s-1];
      end
      d4_ff[8] <= d4_w;
      d4_ff[9] <= d4_ff[8];
   end

   // Products of the weights with the duration.
   for (genvar c = 0; c < 3; c++) begin : g_coef
      qjmt_mul #(.A_W(KW-1)) u_k1d (
         .clock (clock),
         .a     (k1m_ff[c]),
         .d     (d_ff[1]),
         .p     (k1d_w[c])
      );
      qjmt_mul #(.A_W(KW-1)) u_k2d (
         .clock (clock),
         .a     (k2m_ff[c]),
         .d     (d_ff[1]),
         .p     (k2d_w[c])
      );
      qjmt_mul #(.A_W(MW1)) u_k2dd (
         .clock (clock),
         .a     (k2d_w[c]),
         .d     (d_ff[3]),
         .p     (k2dd_w[c])
      );
   end

   // Powers of the duration for the three denominators.
   qjmt_mul #(.A_W(DUR_W)) u_d2 (
      .clock (clock),
      .a     (d_ff[1]),
      .d     (d_ff[1]),
      .p     (dd_w)
   );
   qjmt_mul #(.A_W(2*DUR_W)) u_d3 (
      .clock (clock),
      .a     (dd_w),
      .d     (d_ff[3]),
      .p     (d3_w)
   );
   qjmt_mul #(.A_W(3*DUR_W)) u_d4 (
      .clock (clock),
      .a     (d3_w),
      .d     (d_ff[5]),
      .p     (d4_w)
   );
   qjmt_mul #(.A_W(4*DUR_W)) u_d5 (
      .clock (clock),
      .a     (d4_w),
      .d     (d_ff[7]),
      .p     (d5_w)
   );

   // One divider per higher coefficient.
   qjmt_div #(.SHIFT(31), .DEN_W(3*DUR_W)) u_div3 (
      .clock (clock),
      .mag   (mag_ff[0][9]),
      .neg   (neg_ff[0][9]),
      .zero  (side_ff[9].singular),
      .den   (d3_ff[9]),
      .coef  (coef_w[0]),
      .sat   (sat_w[0])
   );
   qjmt_div #(.SHIFT(31 + INPUT_FRAC_BITS), .DEN_W(4*DUR_W)) u_div4 (
      .clock (clock),
      .mag   (mag_ff[1][9]),
      .neg   (neg_ff[1][9]),
      .zero  (side_ff[9].singular),
      .den   (d4_ff[9]),
      .coef  (coef_w[1]),
      .sat   (sat_w[1])
   );
   qjmt_div #(.SHIFT(31 + 2*INPUT_FRAC_BITS), .DEN_W(5*DUR_W)) u_div5 (
      .clock (clock),
      .mag   (mag_ff[2][9]),
      .neg   (neg_ff[2][9]),
      .zero  (side_ff[9].singular),
      .den   (d5_w),
      .coef  (coef_w[2]),
      .sat   (sat_w[2])
   );

   // Result register.
   always_ff @(posedge clock) begin
      rsp_ff.coef0     <= side_ff[LAST].coef0;
      rsp_ff.coef1     <= side_ff[LAST].coef1;
      rsp_ff.coef2     <= side_ff[LAST].coef2;
      rsp_ff.coef3     <= coef_w[0];
      rsp_ff.coef4     <= coef_w[1];
      rsp_ff.coef5     <= coef_w[2];
      rsp_ff.singular  <= side_ff[LAST].singular;
      rsp_ff.saturated <= sat_w[0] | sat_w[1] | sat_w[2];
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/core/qjmt_check.sv
// Port-level checks of the coefficient engine.
module qjmt_check import qjmt_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          start,
   input logic          busy,
   input qjmt_req_type  req_data,
   input logic          rsp_valid,
   input qjmt_rsp_type  rsp_data
);

   // Every transfer in gives one result after the fixed latency.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##79 rsp_valid)
      else $error("result missing after request");

   // No result without a request at the matching edge.
   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 79))
      else $error("result without request");

   // The singular flag follows the duration of the matching request.
   a_singular_src : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.singular == ($past(req_data.duration, 79) == '0)))
      else $error("singular flag does not match duration");

   // A singular result carries zero higher coefficients and no clamp.
   a_singular_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.singular) |->
         (rsp_data.coef3 == '0 && rsp_data.coef4 == '0 &&
          rsp_data.coef5 == '0 && !rsp_data.saturated))
      else $error("singular result has nonzero coefficients");

   // A clamped result shows at least one limit value.
   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.saturated) |->
         (rsp_data.coef3 == COEF_MAX || rsp_data.coef3 == COEF_MIN ||
          rsp_data.coef4 == COEF_MAX || rsp_data.coef4 == COEF_MIN ||
          rsp_data.coef5 == COEF_MAX || rsp_data.coef5 == COEF_MIN))
      else $error("saturated without a limit value");

endmodule

bind quintic_jerk_min_trajectory qjmt_check u_qjmt_check (.*);
